@@ rtl/assert_macros.svh @@
// assertion macros used by the execute unit
// clocked on clk; ECU_ASSERT checks are off while rst_n is low, ECU_ASSERT_ALWAYS ones are not
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ECU_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("execute unit check failed");

`define ECU_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("execute unit check failed");

`else

`define ECU_ASSERT(lbl, prop)

`define ECU_ASSERT_ALWAYS(lbl, prop)

`endif

`endif

@@ rtl/ecu_pkg.sv @@
`timescale 1ns / 1ps

package ecu_pkg;

  localparam int unsigned CMD_W   = 6;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned ADDR_W  = 16;
  localparam int unsigned IN_W    = 32;
  localparam int unsigned OUT_W   = 80;

  // operation numbers
  localparam logic [CMD_W-1:0] OP_ADC = 6'd0;
  localparam logic [CMD_W-1:0] OP_AND = 6'd1;
  localparam logic [CMD_W-1:0] OP_ASL = 6'd2;
  localparam logic [CMD_W-1:0] OP_BCC = 6'd3;
  localparam logic [CMD_W-1:0] OP_BCS = 6'd4;
  localparam logic [CMD_W-1:0] OP_BEQ = 6'd5;
  localparam logic [CMD_W-1:0] OP_BIT = 6'd6;
  localparam logic [CMD_W-1:0] OP_BMI = 6'd7;
  localparam logic [CMD_W-1:0] OP_BNE = 6'd8;
  localparam logic [CMD_W-1:0] OP_BPL = 6'd9;
  localparam logic [CMD_W-1:0] OP_BVC = 6'd10;
  localparam logic [CMD_W-1:0] OP_BVS = 6'd11;
  localparam logic [CMD_W-1:0] OP_CLC = 6'd12;
  localparam logic [CMD_W-1:0] OP_CLD = 6'd13;
  localparam logic [CMD_W-1:0] OP_CLI = 6'd14;
  localparam logic [CMD_W-1:0] OP_CLV = 6'd15;
  localparam logic [CMD_W-1:0] OP_CMP = 6'd16;
  localparam logic [CMD_W-1:0] OP_CPX = 6'd17;
  localparam logic [CMD_W-1:0] OP_CPY = 6'd18;
  localparam logic [CMD_W-1:0] OP_DEC = 6'd19;
  localparam logic [CMD_W-1:0] OP_DEX = 6'd20;
  localparam logic [CMD_W-1:0] OP_DEY = 6'd21;
  localparam logic [CMD_W-1:0] OP_EOR = 6'd22;
  localparam logic [CMD_W-1:0] OP_INC = 6'd23;
  localparam logic [CMD_W-1:0] OP_INX = 6'd24;
  localparam logic [CMD_W-1:0] OP_INY = 6'd25;
  localparam logic [CMD_W-1:0] OP_JMP = 6'd26;
  localparam logic [CMD_W-1:0] OP_LDA = 6'd27;
  localparam logic [CMD_W-1:0] OP_LDX = 6'd28;
  localparam logic [CMD_W-1:0] OP_LDY = 6'd29;
  localparam logic [CMD_W-1:0] OP_LSR = 6'd30;
  localparam logic [CMD_W-1:0] OP_NOP = 6'd31;
  localparam logic [CMD_W-1:0] OP_ORA = 6'd32;
  localparam logic [CMD_W-1:0] OP_ROL = 6'd33;
  localparam logic [CMD_W-1:0] OP_ROR = 6'd34;
  localparam logic [CMD_W-1:0] OP_SBC = 6'd35;
  localparam logic [CMD_W-1:0] OP_SEC = 6'd36;
  localparam logic [CMD_W-1:0] OP_SED = 6'd37;
  localparam logic [CMD_W-1:0] OP_SEI = 6'd38;
  localparam logic [CMD_W-1:0] OP_STA = 6'd39;
  localparam logic [CMD_W-1:0] OP_STX = 6'd40;
  localparam logic [CMD_W-1:0] OP_STY = 6'd41;
  localparam logic [CMD_W-1:0] OP_TAX = 6'd42;
  localparam logic [CMD_W-1:0] OP_TAY = 6'd43;
  localparam logic [CMD_W-1:0] OP_TSX = 6'd44;
  localparam logic [CMD_W-1:0] OP_TXA = 6'd45;
  localparam logic [CMD_W-1:0] OP_TXS = 6'd46;
  localparam logic [CMD_W-1:0] OP_TYA = 6'd47;

  // status bit positions
  localparam int unsigned FL_C = 0;
  localparam int unsigned FL_Z = 1;
  localparam int unsigned FL_I = 2;
  localparam int unsigned FL_D = 3;
  localparam int unsigned FL_V = 6;
  localparam int unsigned FL_N = 7;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [ADDR_W-1:0] addr_t;

endpackage

@@ rtl/eight_bit_cpu_execute_unit.sv @@
`timescale 1ns / 1ps
// channel | dir | tdata fields, lowest bit first
// in_     | in  | cmd[5:0], operand_value[13:6], operand_address[29:14], zero fill to 32
// out_    | out | acc_out, x_out, y_out, status_out, mem_write, write_address,
//         |     | write_data, jump_taken, jump_target, zero fill to 80
//
// one item per cycle sustained while out_tready stays high; each item goes through
// the input register, then the alu and flag update into the result register
// the register file and flags change as an item moves into the result register
// rst_n (synchronous) clears both stages and zeroes a, x, y, sp and flags
// a stalled result holds the result register and, behind it, the input register

`include "assert_macros.svh"

module eight_bit_cpu_execute_unit (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  // cmd, operand_value, operand_address, zero fill
  input  logic [ecu_pkg::IN_W-1:0] in_tdata,
  output logic                     out_tvalid,
  input  logic                     out_tready,
  // acc_out, x_out, y_out, status_out, mem_write, write_address,
  // write_data, jump_taken, jump_target, zero fill
  output logic [ecu_pkg::OUT_W-1:0] out_tdata
);

  logic                           s1_valid_r;
  logic [ecu_pkg::CMD_W-1:0]      s1_cmd_r;
  ecu_pkg::byte_t                 s1_val_r;
  ecu_pkg::addr_t                 s1_addr_r;

  ecu_pkg::byte_t acc_r, acc_nxt;
  ecu_pkg::byte_t x_r, x_nxt;
  ecu_pkg::byte_t y_r, y_nxt;
  ecu_pkg::byte_t sp_r, sp_nxt;
  ecu_pkg::byte_t flags_r, flags_nxt;

  logic                      out_valid_r;
  logic [ecu_pkg::OUT_W-1:0] out_data_r, out_data_nxt;

  logic           in_go;
  logic           s1_go;
  logic           wr;
  logic           jmp;
  ecu_pkg::byte_t wdata;
  ecu_pkg::byte_t m;
  ecu_pkg::byte_t m_add;
  ecu_pkg::byte_t res;
  ecu_pkg::byte_t cmp_reg;
  logic [8:0]     sum9;
  logic [8:0]     diff9;

  assign in_go     = in_tvalid && in_tready;
  assign s1_go     = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_go;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign m     = s1_val_r;
  assign m_add = (s1_cmd_r == ecu_pkg::OP_SBC) ? ~m : m;
  assign sum9  = {1'b0, acc_r} + {1'b0, m_add} + {8'd0, flags_r[ecu_pkg::FL_C]};

  always_comb begin
    case (s1_cmd_r)
      ecu_pkg::OP_CPX: cmp_reg = x_r;
      ecu_pkg::OP_CPY: cmp_reg = y_r;
      default:         cmp_reg = acc_r;
    endcase
  end

  assign diff9 = {1'b0, cmp_reg} - {1'b0, m};

  always_comb begin
    acc_nxt   = acc_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    sp_nxt    = sp_r;
    flags_nxt = flags_r;
    wr        = 1'b0;
    jmp       = 1'b0;
    wdata     = '0;
    res       = '0;

    case (s1_cmd_r)
      ecu_pkg::OP_ADC, ecu_pkg::OP_SBC: begin
        acc_nxt = sum9[7:0];
        flags_nxt[ecu_pkg::FL_C] = sum9[8];
        // same-sign addends, opposite-sign sum
        flags_nxt[ecu_pkg::FL_V] = ~(acc_r[7] ^ m_add[7]) & (acc_r[7] ^ sum9[7]);
        res = sum9[7:0];
      end
      ecu_pkg::OP_AND: begin acc_nxt = acc_r & m; res = acc_r & m; end
      ecu_pkg::OP_EOR: begin acc_nxt = acc_r ^ m; res = acc_r ^ m; end
      ecu_pkg::OP_ORA: begin acc_nxt = acc_r | m; res = acc_r | m; end
      ecu_pkg::OP_ASL: begin
        res = {m[6:0], 1'b0};
        acc_nxt = res;
        flags_nxt[ecu_pkg::FL_C] = m[7];
      end
      ecu_pkg::OP_LSR: begin
        res = {1'b0, m[7:1]};
        acc_nxt = res;
        flags_nxt[ecu_pkg::FL_C] = m[0];
      end
      ecu_pkg::OP_ROL: begin
        res = {m[6:0], flags_r[ecu_pkg::FL_C]};
        acc_nxt = res;
        flags_nxt[ecu_pkg::FL_C] = m[7];
      end
      ecu_pkg::OP_ROR: begin
        res = {flags_r[ecu_pkg::FL_C], m[7:1]};
        acc_nxt = res;
        flags_nxt[ecu_pkg::FL_C] = m[0];
      end
      ecu_pkg::OP_BCC: jmp = !flags_r[ecu_pkg::FL_C];
      ecu_pkg::OP_BCS: jmp = flags_r[ecu_pkg::FL_C];
      ecu_pkg::OP_BEQ: jmp = flags_r[ecu_pkg::FL_Z];
      ecu_pkg::OP_BNE: jmp = !flags_r[ecu_pkg::FL_Z];
      ecu_pkg::OP_BMI: jmp = flags_r[ecu_pkg::FL_N];
      ecu_pkg::OP_BPL: jmp = !flags_r[ecu_pkg::FL_N];
      ecu_pkg::OP_BVS: jmp = flags_r[ecu_pkg::FL_V];
      ecu_pkg::OP_BVC: jmp = !flags_r[ecu_pkg::FL_V];
      ecu_pkg::OP_JMP: jmp = 1'b1;
      ecu_pkg::OP_BIT: begin
        flags_nxt[ecu_pkg::FL_Z] = ((acc_r & m) == '0);
        flags_nxt[ecu_pkg::FL_V] = m[6];
        flags_nxt[ecu_pkg::FL_N] = m[7];
      end
      ecu_pkg::OP_CLC: flags_nxt[ecu_pkg::FL_C] = 1'b0;
      ecu_pkg::OP_CLD: flags_nxt[ecu_pkg::FL_D] = 1'b0;
      ecu_pkg::OP_CLI: flags_nxt[ecu_pkg::FL_I] = 1'b0;
      ecu_pkg::OP_CLV: flags_nxt[ecu_pkg::FL_V] = 1'b0;
      ecu_pkg::OP_SEC: flags_nxt[ecu_pkg::FL_C] = 1'b1;
      ecu_pkg::OP_SED: flags_nxt[ecu_pkg::FL_D] = 1'b1;
      ecu_pkg::OP_SEI: flags_nxt[ecu_pkg::FL_I] = 1'b1;
      ecu_pkg::OP_CMP, ecu_pkg::OP_CPX, ecu_pkg::OP_CPY: begin
        flags_nxt[ecu_pkg::FL_C] = !diff9[8];
        flags_nxt[ecu_pkg::FL_Z] = (cmp_reg == m);
        flags_nxt[ecu_pkg::FL_N] = diff9[7];
      end
      ecu_pkg::OP_DEC: begin res = m - 8'd1; wr = 1'b1; wdata = res; end
      ecu_pkg::OP_INC: begin res = m + 8'd1; wr = 1'b1; wdata = res; end
      ecu_pkg::OP_DEX: begin res = x_r - 8'd1; x_nxt = res; end
      ecu_pkg::OP_DEY: begin res = y_r - 8'd1; y_nxt = res; end
      ecu_pkg::OP_INX: begin res = x_r + 8'd1; x_nxt = res; end
      ecu_pkg::OP_INY: begin res = y_r + 8'd1; y_nxt = res; end
      ecu_pkg::OP_LDA: begin res = m; acc_nxt = m; end
      ecu_pkg::OP_LDX: begin res = m; x_nxt = m; end
      ecu_pkg::OP_LDY: begin res = m; y_nxt = m; end
      ecu_pkg::OP_STA: begin wr = 1'b1; wdata = acc_r; end
      ecu_pkg::OP_STX: begin wr = 1'b1; wdata = x_r; end
      ecu_pkg::OP_STY: begin wr = 1'b1; wdata = y_r; end
      ecu_pkg::OP_TAX: begin res = acc_r; x_nxt = acc_r; end
      ecu_pkg::OP_TAY: begin res = acc_r; y_nxt = acc_r; end
      ecu_pkg::OP_TSX: begin res = sp_r; x_nxt = sp_r; end
      ecu_pkg::OP_TXA: begin res = x_r; acc_nxt = x_r; end
      ecu_pkg::OP_TYA: begin res = y_r; acc_nxt = y_r; end
      ecu_pkg::OP_TXS: sp_nxt = x_r;
      default: ;
    endcase

    // z and n follow the result byte for every op that loads a result
    case (s1_cmd_r)
      ecu_pkg::OP_ADC, ecu_pkg::OP_SBC, ecu_pkg::OP_AND, ecu_pkg::OP_EOR,
      ecu_pkg::OP_ORA, ecu_pkg::OP_ASL, ecu_pkg::OP_LSR, ecu_pkg::OP_ROL,
      ecu_pkg::OP_ROR, ecu_pkg::OP_DEC, ecu_pkg::OP_INC, ecu_pkg::OP_DEX,
      ecu_pkg::OP_DEY, ecu_pkg::OP_INX, ecu_pkg::OP_INY, ecu_pkg::OP_LDA,
      ecu_pkg::OP_LDX, ecu_pkg::OP_LDY, ecu_pkg::OP_TAX, ecu_pkg::OP_TAY,
      ecu_pkg::OP_TSX, ecu_pkg::OP_TXA, ecu_pkg::OP_TYA: begin
        flags_nxt[ecu_pkg::FL_Z] = (res == '0);
        flags_nxt[ecu_pkg::FL_N] = res[7];
      end
      default: ;
    endcase

    out_data_nxt = {6'd0,
                    jmp ? s1_addr_r : 16'd0,
                    jmp,
                    wr ? wdata : 8'd0,
                    wr ? s1_addr_r : 16'd0,
                    wr,
                    flags_nxt, y_nxt, x_nxt, acc_nxt};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      acc_r       <= '0;
      x_r         <= '0;
      y_r         <= '0;
      sp_r        <= '0;
      flags_r     <= '0;
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (s1_go) begin
        out_valid_r <= 1'b1;
        acc_r       <= acc_nxt;
        x_r         <= x_nxt;
        y_r         <= y_nxt;
        sp_r        <= sp_nxt;
        flags_r     <= flags_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_go) begin
      s1_cmd_r  <= in_tdata[5:0];
      s1_val_r  <= in_tdata[13:6];
      s1_addr_r <= in_tdata[29:14];
    end
    if (s1_go) begin
      out_data_r <= out_data_nxt;
    end
  end

  `ECU_ASSERT(a_wr_fields_zero, out_valid_r && !out_data_r[32] |-> out_data_r[56:33] == '0)
  `ECU_ASSERT(a_jmp_fields_zero, out_valid_r && !out_data_r[57] |-> out_data_r[73:58] == '0)
  `ECU_ASSERT(a_wr_jmp_exclusive, out_valid_r |-> !(out_data_r[32] && out_data_r[57]))
  `ECU_ASSERT(a_s1_held, s1_valid_r && !s1_go |=> s1_valid_r && $stable(s1_cmd_r))
  `ECU_ASSERT(a_unused_flags, flags_r[5:4] == 2'b00 && (sp_r == $past(sp_r) || $past(s1_go)))

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned RUN_LIMIT   = 300000;
  localparam int unsigned RAND_ITEMS  = 1450;
  localparam int unsigned LONG_HOLD   = 100;
  localparam int unsigned DRAIN_WAIT  = 8;
  localparam int unsigned MAX_REPORTS = 10;

  typedef struct packed {
    ecu_pkg::byte_t acc;
    ecu_pkg::byte_t xr;
    ecu_pkg::byte_t yr;
    ecu_pkg::byte_t stat;
    logic           wr;
    ecu_pkg::addr_t waddr;
    ecu_pkg::byte_t wdat;
    logic           jmp;
    ecu_pkg::addr_t jtgt;
  } result_t;

  typedef struct {
    logic [ecu_pkg::CMD_W-1:0] op;
    ecu_pkg::byte_t            mv;
    ecu_pkg::addr_t            adr;
    bit                        pin;
    result_t                   want;
  } stim_row_t;

  typedef enum int {RX_FREE, RX_COIN, RX_MOSTLY, RX_PATTERN} rx_mode_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_tvalid = 1'b0;
  logic                      in_tready;
  logic [ecu_pkg::IN_W-1:0]  in_tdata = '0;
  logic                      out_tvalid;
  logic                      out_tready = 1'b0;
  logic [ecu_pkg::OUT_W-1:0] out_tdata;

  // predicted cpu state
  ecu_pkg::byte_t cpu_a, cpu_x, cpu_y, cpu_sp, cpu_p;

  result_t   exp_q[$];
  stim_row_t dir_rows[$];

  int unsigned err_cnt = 0;
  int unsigned out_cnt = 0;
  int unsigned cyc_cnt = 0;
  int unsigned hold_asks = 0;
  int unsigned hold_done = 0;
  int unsigned hold_left = 0;
  int unsigned rx_left = 0;
  rx_mode_t    rx_mode = RX_FREE;
  logic [7:0]  rx_pat = 8'hFF;
  int unsigned burst_left = 1;
  result_t     got_res, want_res;

  eight_bit_cpu_execute_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void put_zn(ecu_pkg::byte_t v);
    cpu_p[ecu_pkg::FL_Z] = (v == 8'h00);
    cpu_p[ecu_pkg::FL_N] = v[7];
  endfunction

  function automatic void add_carry(ecu_pkg::byte_t mv);
    logic [8:0]     sum;
    ecu_pkg::byte_t r;
    sum = {1'b0, cpu_a} + {1'b0, mv} + {8'h00, cpu_p[ecu_pkg::FL_C]};
    r = sum[7:0];
    cpu_p[ecu_pkg::FL_C] = sum[8];
    cpu_p[ecu_pkg::FL_V] = ~(cpu_a[7] ^ mv[7]) & (cpu_a[7] ^ r[7]);
    cpu_a = r;
    put_zn(r);
  endfunction

  function automatic void cmp_reg(ecu_pkg::byte_t rg, ecu_pkg::byte_t mv);
    ecu_pkg::byte_t d;
    d = rg - mv;
    cpu_p[ecu_pkg::FL_C] = (rg >= mv);
    cpu_p[ecu_pkg::FL_Z] = (rg == mv);
    cpu_p[ecu_pkg::FL_N] = d[7];
  endfunction

  // one instruction against the predicted state, returns the result item
  function automatic result_t exec_op(logic [ecu_pkg::CMD_W-1:0] op, ecu_pkg::byte_t mv,
                                      ecu_pkg::addr_t adr);
    result_t        r;
    logic           wr, br, tk;
    ecu_pkg::byte_t wd, t;
    wr = 1'b0;
    br = 1'b0;
    tk = 1'b0;
    wd = '0;
    t  = '0;
    case (op)
      ecu_pkg::OP_ADC: add_carry(mv);
      ecu_pkg::OP_SBC: add_carry(~mv);
      ecu_pkg::OP_AND: begin cpu_a = cpu_a & mv; put_zn(cpu_a); end
      ecu_pkg::OP_EOR: begin cpu_a = cpu_a ^ mv; put_zn(cpu_a); end
      ecu_pkg::OP_ORA: begin cpu_a = cpu_a | mv; put_zn(cpu_a); end
      ecu_pkg::OP_ASL: begin
        cpu_p[ecu_pkg::FL_C] = mv[7];
        cpu_a = {mv[6:0], 1'b0};
        put_zn(cpu_a);
      end
      ecu_pkg::OP_LSR: begin
        cpu_p[ecu_pkg::FL_C] = mv[0];
        cpu_a = {1'b0, mv[7:1]};
        put_zn(cpu_a);
      end
      ecu_pkg::OP_ROL: begin
        t = {mv[6:0], cpu_p[ecu_pkg::FL_C]};
        cpu_p[ecu_pkg::FL_C] = mv[7];
        cpu_a = t;
        put_zn(t);
      end
      ecu_pkg::OP_ROR: begin
        t = {cpu_p[ecu_pkg::FL_C], mv[7:1]};
        cpu_p[ecu_pkg::FL_C] = mv[0];
        cpu_a = t;
        put_zn(t);
      end
      ecu_pkg::OP_BCC: begin br = 1'b1; tk = !cpu_p[ecu_pkg::FL_C]; end
      ecu_pkg::OP_BCS: begin br = 1'b1; tk = cpu_p[ecu_pkg::FL_C]; end
      ecu_pkg::OP_BEQ: begin br = 1'b1; tk = cpu_p[ecu_pkg::FL_Z]; end
      ecu_pkg::OP_BNE: begin br = 1'b1; tk = !cpu_p[ecu_pkg::FL_Z]; end
      ecu_pkg::OP_BMI: begin br = 1'b1; tk = cpu_p[ecu_pkg::FL_N]; end
      ecu_pkg::OP_BPL: begin br = 1'b1; tk = !cpu_p[ecu_pkg::FL_N]; end
      ecu_pkg::OP_BVS: begin br = 1'b1; tk = cpu_p[ecu_pkg::FL_V]; end
      ecu_pkg::OP_BVC: begin br = 1'b1; tk = !cpu_p[ecu_pkg::FL_V]; end
      ecu_pkg::OP_JMP: begin br = 1'b1; tk = 1'b1; end
      ecu_pkg::OP_BIT: begin
        cpu_p[ecu_pkg::FL_Z] = ((cpu_a & mv) == 8'h00);
        cpu_p[ecu_pkg::FL_V] = mv[6];
        cpu_p[ecu_pkg::FL_N] = mv[7];
      end
      ecu_pkg::OP_CLC: cpu_p[ecu_pkg::FL_C] = 1'b0;
      ecu_pkg::OP_CLD: cpu_p[ecu_pkg::FL_D] = 1'b0;
      ecu_pkg::OP_CLI: cpu_p[ecu_pkg::FL_I] = 1'b0;
      ecu_pkg::OP_CLV: cpu_p[ecu_pkg::FL_V] = 1'b0;
      ecu_pkg::OP_SEC: cpu_p[ecu_pkg::FL_C] = 1'b1;
      ecu_pkg::OP_SED: cpu_p[ecu_pkg::FL_D] = 1'b1;
      ecu_pkg::OP_SEI: cpu_p[ecu_pkg::FL_I] = 1'b1;
      ecu_pkg::OP_CMP: cmp_reg(cpu_a, mv);
      ecu_pkg::OP_CPX: cmp_reg(cpu_x, mv);
      ecu_pkg::OP_CPY: cmp_reg(cpu_y, mv);
      ecu_pkg::OP_DEC: begin t = mv - 8'h01; put_zn(t); wr = 1'b1; wd = t; end
      ecu_pkg::OP_INC: begin t = mv + 8'h01; put_zn(t); wr = 1'b1; wd = t; end
      ecu_pkg::OP_DEX: begin cpu_x = cpu_x - 8'h01; put_zn(cpu_x); end
      ecu_pkg::OP_DEY: begin cpu_y = cpu_y - 8'h01; put_zn(cpu_y); end
      ecu_pkg::OP_INX: begin cpu_x = cpu_x + 8'h01; put_zn(cpu_x); end
      ecu_pkg::OP_INY: begin cpu_y = cpu_y + 8'h01; put_zn(cpu_y); end
      ecu_pkg::OP_LDA: begin cpu_a = mv; put_zn(mv); end
      ecu_pkg::OP_LDX: begin cpu_x = mv; put_zn(mv); end
      ecu_pkg::OP_LDY: begin cpu_y = mv; put_zn(mv); end
      ecu_pkg::OP_STA: begin wr = 1'b1; wd = cpu_a; end
      ecu_pkg::OP_STX: begin wr = 1'b1; wd = cpu_x; end
      ecu_pkg::OP_STY: begin wr = 1'b1; wd = cpu_y; end
      ecu_pkg::OP_TAX: begin cpu_x = cpu_a; put_zn(cpu_x); end
      ecu_pkg::OP_TAY: begin cpu_y = cpu_a; put_zn(cpu_y); end
      ecu_pkg::OP_TSX: begin cpu_x = cpu_sp; put_zn(cpu_x); end
      ecu_pkg::OP_TXA: begin cpu_a = cpu_x; put_zn(cpu_a); end
      ecu_pkg::OP_TXS: cpu_sp = cpu_x;
      ecu_pkg::OP_TYA: begin cpu_a = cpu_y; put_zn(cpu_a); end
      default: ;
    endcase
    r.acc   = cpu_a;
    r.xr    = cpu_x;
    r.yr    = cpu_y;
    r.stat  = cpu_p;
    r.wr    = wr;
    r.waddr = wr ? adr : '0;
    r.wdat  = wr ? wd : '0;
    r.jmp   = br & tk;
    r.jtgt  = (br & tk) ? adr : '0;
    return r;
  endfunction

  function automatic result_t mk_res(ecu_pkg::byte_t a, ecu_pkg::byte_t x,
                                     ecu_pkg::byte_t y, ecu_pkg::byte_t p, logic w,
                                     ecu_pkg::addr_t wa, ecu_pkg::byte_t wd, logic j,
                                     ecu_pkg::addr_t jt);
    result_t r;
    r.acc   = a;
    r.xr    = x;
    r.yr    = y;
    r.stat  = p;
    r.wr    = w;
    r.waddr = wa;
    r.wdat  = wd;
    r.jmp   = j;
    r.jtgt  = jt;
    return r;
  endfunction

  function automatic void add_row(logic [ecu_pkg::CMD_W-1:0] op, ecu_pkg::byte_t mv,
                                  ecu_pkg::addr_t adr);
    stim_row_t s;
    s.op   = op;
    s.mv   = mv;
    s.adr  = adr;
    s.pin  = 1'b0;
    s.want = '0;
    dir_rows.push_back(s);
  endfunction

  function automatic void add_pinned(logic [ecu_pkg::CMD_W-1:0] op, ecu_pkg::byte_t mv,
                                     ecu_pkg::addr_t adr, result_t w);
    stim_row_t s;
    s.op   = op;
    s.mv   = mv;
    s.adr  = adr;
    s.pin  = 1'b1;
    s.want = w;
    dir_rows.push_back(s);
  endfunction

  // offer one item, hold it until taken, then log what should come out
  task automatic put_item(logic [ecu_pkg::CMD_W-1:0] op, ecu_pkg::byte_t mv,
                          ecu_pkg::addr_t adr, bit pin, result_t pin_res);
    result_t r;
    in_tvalid <= 1'b1;
    in_tdata  <= {{(ecu_pkg::IN_W-ecu_pkg::CMD_W-ecu_pkg::BYTE_W-ecu_pkg::ADDR_W){1'b0}},
                  adr, mv, op};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    r = exec_op(op, mv, adr);
    exp_q.push_back(pin ? pin_res : r);
  endtask

  // sender bursts: gaps of random length between bursts, some long bursts
  task automatic pace();
    int unsigned gap;
    burst_left--;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 10);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 150)
                                               : $urandom_range(1, 12);
    end
  endtask

  task automatic check_field(string fname, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      err_cnt++;
      if (err_cnt <= MAX_REPORTS)
        $display("item %0d %s: expected %h, got %h", out_cnt, fname, want, got);
    end
  endtask

  function automatic ecu_pkg::byte_t pick_byte();
    ecu_pkg::byte_t edges[5];
    edges = '{8'h00, 8'h01, 8'h7F, 8'h80, 8'hFF};
    if ($urandom_range(0, 5) == 0) return edges[$urandom_range(0, 4)];
    return ecu_pkg::byte_t'($urandom_range(0, 255));
  endfunction

  // result side: stall modes of its own, plus long holds on request
  always @(posedge clk) begin
    if (hold_asks != hold_done) begin
      hold_done++;
      hold_left = LONG_HOLD;
    end
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_left = $urandom_range(20, 200);
      rx_pat  = 8'($urandom_range(1, 255));
    end else begin
      rx_left--;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_FREE:   out_tready <= 1'b1;
        RX_COIN:   out_tready <= 1'($urandom_range(0, 1));
        RX_MOSTLY: out_tready <= ($urandom_range(0, 4) != 0);
        default: begin
          out_tready <= rx_pat[0];
          rx_pat = {rx_pat[0], rx_pat[7:1]};
        end
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_res.acc   = out_tdata[7:0];
      got_res.xr    = out_tdata[15:8];
      got_res.yr    = out_tdata[23:16];
      got_res.stat  = out_tdata[31:24];
      got_res.wr    = out_tdata[32];
      got_res.waddr = out_tdata[48:33];
      got_res.wdat  = out_tdata[56:49];
      got_res.jmp   = out_tdata[57];
      got_res.jtgt  = out_tdata[73:58];
      if (exp_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= MAX_REPORTS)
          $display("item %0d: result with nothing expected, data %h", out_cnt, out_tdata);
      end else begin
        want_res = exp_q.pop_front();
        check_field("acc_out",       16'(want_res.acc),   16'(got_res.acc));
        check_field("x_out",         16'(want_res.xr),    16'(got_res.xr));
        check_field("y_out",         16'(want_res.yr),    16'(got_res.yr));
        check_field("status_out",    16'(want_res.stat),  16'(got_res.stat));
        check_field("mem_write",     16'(want_res.wr),    16'(got_res.wr));
        check_field("write_address", want_res.waddr,      got_res.waddr);
        check_field("write_data",    16'(want_res.wdat),  16'(got_res.wdat));
        check_field("jump_taken",    16'(want_res.jmp),   16'(got_res.jmp));
        check_field("jump_target",   want_res.jtgt,       got_res.jtgt);
      end
      out_cnt++;
    end
  end

  always @(posedge clk) begin
    cyc_cnt++;
    if (cyc_cnt > RUN_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    logic [ecu_pkg::CMD_W-1:0] op;
    cpu_a  = '0;
    cpu_x  = '0;
    cpu_y  = '0;
    cpu_sp = '0;
    cpu_p  = '0;

    // right after reset every register and flag is zero
    add_pinned(ecu_pkg::OP_NOP, 8'hFF, 16'hFFFF, mk_res(0, 0, 0, 0, 0, 0, 0, 0, 0));
    add_pinned(ecu_pkg::OP_BNE, 8'h00, 16'h1234,
               mk_res(0, 0, 0, 0, 0, 0, 0, 1, 16'h1234));
    add_pinned(ecu_pkg::OP_BEQ, 8'hFF, 16'hFFFF, mk_res(0, 0, 0, 0, 0, 0, 0, 0, 0));
    add_pinned(ecu_pkg::OP_STA, 8'h5A, 16'hFFFF,
               mk_res(0, 0, 0, 0, 1, 16'hFFFF, 0, 0, 0));
    add_pinned(ecu_pkg::OP_LDA, 8'hFF, 16'h0000,
               mk_res(8'hFF, 0, 0, 8'h80, 0, 0, 0, 0, 0));
    // carry out to zero, then signed overflow into bit 7
    add_pinned(ecu_pkg::OP_ADC, 8'h01, 16'h0000,
               mk_res(8'h00, 0, 0, 8'h03, 0, 0, 0, 0, 0));
    add_pinned(ecu_pkg::OP_LDA, 8'h7F, 16'h0000,
               mk_res(8'h7F, 0, 0, 8'h01, 0, 0, 0, 0, 0));
    add_pinned(ecu_pkg::OP_ADC, 8'h00, 16'h0000,
               mk_res(8'h80, 0, 0, 8'hC0, 0, 0, 0, 0, 0));
    add_row(ecu_pkg::OP_SBC, 8'h00, 16'h0000);
    add_row(ecu_pkg::OP_BVS, 8'h00, 16'hFFFF);
    add_row(ecu_pkg::OP_BVC, 8'h00, 16'h8000);
    add_row(ecu_pkg::OP_BCS, 8'h00, 16'h0001);
    add_row(ecu_pkg::OP_BCC, 8'h00, 16'h0002);
    add_row(ecu_pkg::OP_BMI, 8'h00, 16'hAAAA);
    add_row(ecu_pkg::OP_BPL, 8'h00, 16'h5555);
    add_row(6'd48, 8'hFF, 16'hFFFF);
    add_row(6'd63, 8'h00, 16'h0000);
    // bit test: v and n straight from the operand
    add_row(ecu_pkg::OP_BIT, 8'hC0, 16'h0000);
    add_row(ecu_pkg::OP_BIT, 8'h3F, 16'h0000);
    add_row(ecu_pkg::OP_CLV, 8'h00, 16'h0000);
    add_row(ecu_pkg::OP_SEC, 8'h00, 16'h0000);
    add_row(ecu_pkg::OP_ROR, 8'h01, 16'h0000);
    add_row(ecu_pkg::OP_ROL, 8'hFF, 16'h0000);
    add_row(ecu_pkg::OP_CLC, 8'h00, 16'h0000);
    add_row(ecu_pkg::OP_ROL, 8'h80, 16'h0000);
    add_row(ecu_pkg::OP_ROR, 8'hFE, 16'h0000);
    add_row(ecu_pkg::OP_ASL, 8'h80, 16'h0000);
    add_row(ecu_pkg::OP_LSR, 8'h01, 16'h0000);
    add_row(ecu_pkg::OP_LDX, 8'hFF, 16'h0000);
    add_row(ecu_pkg::OP_LDY, 8'h80, 16'h0000);
    add_row(ecu_pkg::OP_CMP, 8'h00, 16'h0000);
    add_row(ecu_pkg::OP_CMP, 8'hFF, 16'h0000);
    add_row(ecu_pkg::OP_CPX, 8'hFF, 16'h0000);
    add_row(ecu_pkg::OP_CPY, 8'h81, 16'h0000);
    add_row(ecu_pkg::OP_DEC, 8'h00, 16'hFFFF);
    add_row(ecu_pkg::OP_INC, 8'hFF, 16'h0000);
    add_row(ecu_pkg::OP_INX, 8'h00, 16'h0000);
    add_row(ecu_pkg::OP_DEX, 8'h00, 16'h0000);
    add_row(ecu_pkg::OP_INY, 8'h00, 16'h0000);
    add_row(ecu_pkg::OP_DEY, 8'h00, 16'h0000);
    add_row(ecu_pkg::OP_LDA, 8'hA5, 16'h0000);
    add_row(ecu_pkg::OP_EOR, 8'hFF, 16'h0000);
    add_row(ecu_pkg::OP_AND, 8'h00, 16'h0000);
    add_row(ecu_pkg::OP_ORA, 8'h80, 16'h0000);
    add_row(ecu_pkg::OP_SED, 8'h00, 16'h0000);
    add_row(ecu_pkg::OP_SEI, 8'h00, 16'h0000);
    add_row(ecu_pkg::OP_CLD, 8'h00, 16'h0000);
    add_row(ecu_pkg::OP_CLI, 8'h00, 16'h0000);
    add_row(ecu_pkg::OP_JMP, 8'hFF, 16'h0000);
    add_row(ecu_pkg::OP_JMP, 8'h00, 16'hFFFF);
    add_row(ecu_pkg::OP_TSX, 8'h00, 16'h0000);
    add_row(ecu_pkg::OP_TAX, 8'h00, 16'h0000);
    add_row(ecu_pkg::OP_TXS, 8'h00, 16'h0000);
    add_row(ecu_pkg::OP_TAY, 8'h00, 16'h0000);
    add_row(ecu_pkg::OP_LDX, 8'h33, 16'h0000);
    add_row(ecu_pkg::OP_TXA, 8'h00, 16'h0000);
    add_row(ecu_pkg::OP_TXS, 8'h00, 16'h0000);
    add_row(ecu_pkg::OP_TSX, 8'h00, 16'h0000);
    add_row(ecu_pkg::OP_TYA, 8'h00, 16'h0000);
    add_row(ecu_pkg::OP_STX, 8'h00, 16'h8001);
    add_row(ecu_pkg::OP_STY, 8'h00, 16'h7FFE);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      put_item(dir_rows[i].op, dir_rows[i].mv, dir_rows[i].adr, dir_rows[i].pin,
               dir_rows[i].want);
      pace();
    end

    for (int unsigned n = 0; n < RAND_ITEMS; n++) begin
      // receiver holds off while the sender keeps offering
      if (n == 400 || n == 1100) hold_asks++;
      // sender stands still until everything has drained
      if (n == 800) begin
        in_tvalid <= 1'b0;
        do @(posedge clk); while (exp_q.size() != 0);
      end
      op = ($urandom_range(0, 9) == 0) ? ecu_pkg::CMD_W'($urandom_range(48, 63))
                                       : ecu_pkg::CMD_W'($urandom_range(0, 47));
      put_item(op, pick_byte(),
               ($urandom_range(0, 9) == 0) ? ($urandom_range(0, 1) ? 16'hFFFF : 16'h0000)
                                           : ecu_pkg::addr_t'($urandom_range(0, 65535)),
               1'b0, '0);
      pace();
    end

    in_tvalid <= 1'b0;
    while (exp_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (err_cnt == 0 && exp_q.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
